// ----- rtl/pfde_pkg.sv -----
package pfde_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int GLYPH_COLS    = 5;
  localparam int GLYPH_ROWS    = 7;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  localparam int PAGE_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int X_W           = $clog2(SCREEN_WIDTH);
  localparam int COORD_W       = 12;

  localparam logic signed [COORD_W-1:0] SCR_W_C = COORD_W'(SCREEN_WIDTH);
  localparam logic signed [COORD_W-1:0] SCR_H_C = COORD_W'(SCREEN_HEIGHT);

  // Opcodes
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_PIXEL = 3'd1;
  localparam logic [2:0] OP_HLINE = 3'd2;
  localparam logic [2:0] OP_VLINE = 3'd3;
  localparam logic [2:0] OP_RECT  = 3'd4;
  localparam logic [2:0] OP_GLYPH = 3'd5;
  localparam logic [2:0] OP_READ  = 3'd6;

  // Kinds of pixel walk the datapath can load
  typedef enum logic [2:0] {
    SEG_PIXEL, SEG_HLINE, SEG_VLINE, SEG_R0, SEG_R1, SEG_R2, SEG_R3, SEG_GLYPH
  } seg_t;

  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_t;

  typedef struct packed {
    logic load;
    logic seg_load;
    seg_t seg;
    logic step;
    logic mem_rd;
    logic rd_sel;
    logic mem_wr;
    logic clr_step;
    logic res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic pix_hit;
    logic clr_last;
    logic rect_ok;
    logic out_busy;
  } dp_sts_t;

  // 5x7 font; unknown codes are blank
  function automatic glyph_t font_lookup(input logic [6:0] code);
    glyph_t g;
    case (code)
      7'h3A: g = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      7'h30: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      7'h31: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      7'h32: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      7'h33: g = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      7'h34: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      7'h35: g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      7'h36: g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      7'h37: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      7'h38: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      7'h39: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      7'h41: g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      7'h42: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      7'h43: g = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
      7'h44: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      7'h45: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      7'h46: g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      7'h49: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      7'h4C: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      7'h4D: g = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11};
      7'h4E: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      7'h4F: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      7'h53: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      7'h54: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      7'h55: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      7'h61: g = {5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h13, 5'h0D};
      7'h64: g = {5'h01, 5'h01, 5'h0D, 5'h13, 5'h11, 5'h13, 5'h0D};
      7'h65: g = {5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h11, 5'h0E};
      7'h6E: g = {5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11, 5'h11};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/pfde_datapath.sv -----
module pfde_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pfde_pkg::dp_cmd_t   cmd,
  output pfde_pkg::dp_sts_t   sts,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  logic [2:0]          opcode,
  input  logic signed [9:0]   pos_x,
  input  logic signed [9:0]   pos_y,
  input  logic signed [9:0]   line_end_or_width,
  input  logic signed [9:0]   rect_height,
  input  logic                pixel_on,
  input  logic [6:0]          char_code,
  input  logic [2:0]          scale_x,
  input  logic [2:0]          scale_y,
  input  logic                use_cursor,
  input  logic [9:0]          read_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          read_data,
  output logic signed [9:0]   next_cursor
);
  import pfde_pkg::*;

  logic [3:0]                spacing;
  logic [9:0]                cursor;
  logic signed [COORD_W-1:0] px, py, pe, ph, gx;
  logic signed [COORD_W-1:0] cx, cy, cend, base_x;
  logic                      horiz, gmode, draw_on, is_read;
  glyph_t                    g;
  logic [2:0]                sxr, syr, col, row, dx, dy;
  logic [9:0]                ridx;
  logic [7:0]                mem [STORE_BYTES];
  logic [7:0]                mem_q;
  logic [ADDR_W-1:0]         clr_addr;

  logic [9:0]                cur_start, cur_adv;
  logic signed [COORD_W-1:0] ex, ey, cpx, cpy;
  logic [PAGE_W-1:0]         page;
  logic [ADDR_W-1:0]         pix_addr, rd_addr;
  logic [7:0]                mask, wdata;
  logic                      in_screen, dot, walk_done;

  // Derived coordinates
  assign cur_start = use_cursor ? cursor : pos_x;
  assign cur_adv   = 10'(scale_x) * 10'd5 + 10'(spacing);
  assign ex  = px + pe - COORD_W'(1);
  assign ey  = py + ph - COORD_W'(1);
  assign cpx = (px < 0) ? '0 : px;
  assign cpy = (py < 0) ? '0 : py;

  // Current pixel
  assign in_screen = (cx >= 0) && (cx < SCR_W_C) && (cy >= 0) && (cy < SCR_H_C);
  assign page      = PAGE_W'(cy >>> 3);
  assign pix_addr  = ADDR_W'(cx[X_W-1:0]) + ADDR_W'(page * SCREEN_WIDTH);
  assign mask      = 8'(1) << cy[2:0];
  assign wdata     = draw_on ? (mem_q | mask) : (mem_q & ~mask);
  assign rd_addr   = cmd.rd_sel ? ADDR_W'(ridx) : pix_addr;
  assign walk_done = gmode ? (row == 3'(GLYPH_ROWS))
                   : horiz ? ((cx > cend) || (cx >= SCR_W_C))
                           : ((cy > cend) || (cy >= SCR_H_C));
  assign dot = g[row][3'(GLYPH_COLS - 1) - col];

  assign sts.walk_done = walk_done;
  assign sts.pix_hit   = !walk_done && in_screen && (!gmode || dot);
  assign sts.clr_last  = (clr_addr == ADDR_W'(STORE_BYTES - 1));
  assign sts.rect_ok   = (line_end_or_width > 0) && (rect_height > 0);
  assign sts.out_busy  = out_valid && out_stall;

  // Hold config and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= 4'd1;
      cursor  <= '0;
    end else begin
      if (cfg_we) spacing <= cfg_wdata;
      if (cmd.load && opcode == OP_GLYPH) cursor <= cur_start + cur_adv;
    end
  end

  // Latch command fields on the input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px      <= COORD_W'(pos_x);
      py      <= COORD_W'(pos_y);
      pe      <= COORD_W'(line_end_or_width);
      ph      <= COORD_W'(rect_height);
      gx      <= COORD_W'($signed(cur_start));
      g       <= font_lookup(char_code);
      sxr     <= scale_x;
      syr     <= scale_y;
      draw_on <= (opcode == OP_PIXEL) ? pixel_on : 1'b1;
      is_read <= (opcode == OP_READ);
      ridx    <= read_index;
    end
  end

  // Pixel walker: load a segment, then advance one pixel a step
  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      gmode <= 1'b0;
      horiz <= 1'b1;
      case (cmd.seg)
        SEG_PIXEL: begin cx <= cpx; cy <= py; cend <= px; end
        SEG_HLINE: begin cx <= cpx; cy <= py; cend <= pe; end
        SEG_VLINE: begin horiz <= 1'b0; cy <= cpy; cx <= px; cend <= pe; end
        SEG_R0:    begin cx <= cpx; cy <= py; cend <= ex; end
        SEG_R1:    begin cx <= cpx; cy <= ey; cend <= ex; end
        SEG_R2:    begin horiz <= 1'b0; cy <= cpy; cx <= px; cend <= ey; end
        SEG_R3:    begin horiz <= 1'b0; cy <= cpy; cx <= ex; cend <= ey; end
        SEG_GLYPH: begin
          gmode  <= 1'b1;
          cx     <= gx;
          base_x <= gx;
          cy     <= py;
          col    <= '0;
          dx     <= '0;
          dy     <= '0;
          row    <= (sxr == '0 || syr == '0) ? 3'(GLYPH_ROWS) : '0;
        end
        default: cend <= '0;
      endcase
    end else if (cmd.step) begin
      if (!gmode) begin
        if (horiz) cx <= cx + COORD_W'(1);
        else       cy <= cy + COORD_W'(1);
      end else if (dx != sxr - 3'd1) begin
        dx <= dx + 3'd1;
        cx <= cx + COORD_W'(1);
      end else if (col != 3'(GLYPH_COLS - 1)) begin
        dx  <= '0;
        col <= col + 3'd1;
        cx  <= cx + COORD_W'(1);
      end else begin
        dx  <= '0;
        col <= '0;
        cx  <= base_x;
        cy  <= cy + COORD_W'(1);
        if (dy == syr - 3'd1) begin
          dy  <= '0;
          row <= row + 3'd1;
        end else begin
          dy <= dy + 3'd1;
        end
      end
    end
  end

  // Frame store: clear sweep or read-modify-write
  always_ff @(posedge clk) begin
    if (cmd.clr_step)    mem[clr_addr] <= '0;
    else if (cmd.mem_wr) mem[pix_addr] <= wdata;
    if (cmd.mem_rd)      mem_q <= mem[rd_addr];
  end

  // Advance the clear pointer
  always_ff @(posedge clk) begin
    if (rst || cmd.load) clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= sts.clr_last ? '0 : clr_addr + ADDR_W'(1);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.res_load) out_valid <= 1'b1;
    else if (!out_stall)   out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      read_data   <= (is_read && (11'(ridx) < 11'(STORE_BYTES))) ? mem_q : 8'd0;
      next_cursor <= cursor;
    end
  end

endmodule

// ----- rtl/pfde_ctrl.sv -----
module pfde_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  pfde_pkg::dp_sts_t sts,
  output pfde_pkg::dp_cmd_t cmd
);
  import pfde_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CLEAR, S_SEG, S_PIX, S_WR, S_RD, S_DONE
  } state_t;

  state_t state, state_next;
  seg_t   seg, seg_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Sequence the command
  always_comb begin
    cmd        = '0;
    cmd.seg    = seg;
    state_next = state;
    seg_next   = seg;
    case (state)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_SEG;
          case (opcode)
            OP_CLEAR: state_next = S_CLEAR;
            OP_PIXEL: seg_next = SEG_PIXEL;
            OP_HLINE: seg_next = SEG_HLINE;
            OP_VLINE: seg_next = SEG_VLINE;
            OP_RECT: begin
              seg_next = SEG_R0;
              if (!sts.rect_ok) state_next = S_DONE;
            end
            OP_GLYPH: seg_next = SEG_GLYPH;
            OP_READ:  state_next = S_RD;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_DONE;
      end
      S_SEG: begin
        cmd.seg_load = 1'b1;
        state_next   = S_PIX;
      end
      S_PIX: begin
        if (sts.walk_done) begin
          if (seg == SEG_R0 || seg == SEG_R1 || seg == SEG_R2) begin
            seg_next   = seg_t'(seg + 3'd1);
            state_next = S_SEG;
          end else begin
            state_next = S_DONE;
          end
        end else if (sts.pix_hit) begin
          cmd.mem_rd = 1'b1;
          state_next = S_WR;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        cmd.step   = 1'b1;
        state_next = S_PIX;
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      seg   <= SEG_PIXEL;
    end else begin
      state <= state_next;
      seg   <= seg_next;
    end
  end

  // A write always follows the read of the same pixel
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> $past(state) == S_PIX && $past(cmd.mem_rd))
    else $error("write without preceding read");

  // Memory port is never claimed twice
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_wr && cmd.clr_step))
    else $error("clear and pixel write collide");

  // A beat leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted beat not started");

  // Result loads only into a free output register
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !sts.out_busy)
    else $error("result overwrites a held beat");

endmodule

// ----- rtl/page_framebuffer_draw_engine.sv -----
// Channel  Handshake           Payload
// in       in_valid/in_stall   opcode, pos_x, pos_y, line_end_or_width, rect_height,
//                              pixel_on, char_code, scale_x, scale_y, use_cursor, read_index
// out      out_valid/out_stall read_data, next_cursor
// cfg      cfg_we              cfg_wdata (char_spacing)
//
// One command is in work at a time; the next is taken once the result sits in the
// output register. A drawn pixel is a read then a write of the single frame store
// port, while a clipped or blank dot is only stepped over; clear and the reset clearing
// pass sweep the store at one byte a cycle. A read fetches the addressed byte for output.
// Reset is synchronous; no command is taken during the clearing pass.
module page_framebuffer_draw_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  logic signed [9:0] pos_x,
  input  logic signed [9:0] pos_y,
  input  logic signed [9:0] line_end_or_width,
  input  logic signed [9:0] rect_height,
  input  logic              pixel_on,
  input  logic [6:0]        char_code,
  input  logic [2:0]        scale_x,
  input  logic [2:0]        scale_y,
  input  logic              use_cursor,
  input  logic [9:0]        read_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        read_data,
  output logic signed [9:0] next_cursor
);
  import pfde_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pfde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfde_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .opcode            (opcode),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .line_end_or_width (line_end_or_width),
    .rect_height       (rect_height),
    .pixel_on          (pixel_on),
    .char_code         (char_code),
    .scale_x           (scale_x),
    .scale_y           (scale_y),
    .use_cursor        (use_cursor),
    .read_index        (read_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .read_data         (read_data),
    .next_cursor       (next_cursor)
  );

endmodule

// ----- sim/page_framebuffer_draw_engine_test.sv -----
module page_framebuffer_draw_engine_test;
  import pfde_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [2:0]        op;
    logic signed [9:0] x;
    logic signed [9:0] y;
    logic signed [9:0] ew;
    logic signed [9:0] h;
    logic              on;
    logic [6:0]        ch;
    logic [2:0]        sx;
    logic [2:0]        sy;
    logic              uc;
    logic [9:0]        ri;
  } draw_cmd_t;

  typedef struct {
    logic [7:0]        rd;
    logic signed [9:0] cur;
  } draw_res_t;

  // Font: code, then rows top to bottom, 5 bits each, MSB is the left column
  localparam logic [41:0] FONT [30] = '{
    {7'h20, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    {7'h3A, 5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00},
    {7'h30, 5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    {7'h31, 5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    {7'h32, 5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
    {7'h33, 5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
    {7'h34, 5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    {7'h35, 5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
    {7'h36, 5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    {7'h37, 5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    {7'h38, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    {7'h39, 5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
    {7'h41, 5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    {7'h42, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
    {7'h43, 5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
    {7'h44, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
    {7'h45, 5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
    {7'h46, 5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
    {7'h49, 5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    {7'h4C, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
    {7'h4D, 5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11},
    {7'h4E, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
    {7'h4F, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    {7'h53, 5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
    {7'h54, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
    {7'h55, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    {7'h61, 5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h13, 5'h0D},
    {7'h64, 5'h01, 5'h01, 5'h0D, 5'h13, 5'h11, 5'h13, 5'h0D},
    {7'h65, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h11, 5'h0E},
    {7'h6E, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11, 5'h11}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [3:0]        cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        opcode = '0;
  logic signed [9:0] pos_x = '0;
  logic signed [9:0] pos_y = '0;
  logic signed [9:0] line_end_or_width = '0;
  logic signed [9:0] rect_height = '0;
  logic              pixel_on = 1'b0;
  logic [6:0]        char_code = '0;
  logic [2:0]        scale_x = '0;
  logic [2:0]        scale_y = '0;
  logic              use_cursor = 1'b0;
  logic [9:0]        read_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        read_data;
  logic signed [9:0] next_cursor;

  // Predictor state
  logic [7:0] shadow_fb [STORE_BYTES];
  logic [9:0] shadow_cursor;
  logic [3:0] shadow_spacing;
  draw_res_t  pending_results [$];
  int         err_count;
  int         idle_cycles;
  int         burst_left;

  page_framebuffer_draw_engine i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .pos_x(pos_x),
    .pos_y(pos_y), .line_end_or_width(line_end_or_width), .rect_height(rect_height),
    .pixel_on(pixel_on), .char_code(char_code), .scale_x(scale_x), .scale_y(scale_y),
    .use_cursor(use_cursor), .read_index(read_index), .out_valid(out_valid),
    .out_stall(out_stall), .read_data(read_data), .next_cursor(next_cursor)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  function automatic void plot(input int x, input int y, input bit on);
    int idx;
    if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT) return;
    idx = x + (y / 8) * SCREEN_WIDTH;
    shadow_fb[idx][y % 8] = on;
  endfunction

  function automatic logic [34:0] glyph_bits(input logic [6:0] code);
    for (int i = 0; i < 30; i++)
      if (FONT[i][41:35] == code) return FONT[i][34:0];
    return '0;
  endfunction

  // Apply one command to the shadow screen and return its result
  function automatic draw_res_t predict_draw(input draw_cmd_t c);
    draw_res_t r;
    int x, y, e, h, sx, sy, start;
    logic [34:0] g;
    r.rd = '0;
    x = c.x; y = c.y; e = c.ew; h = c.h;
    sx = c.sx; sy = c.sy;
    case (c.op)
      OP_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = '0;
      OP_PIXEL: plot(x, y, c.on);
      OP_HLINE: for (int i = x; i <= e; i++) plot(i, y, 1'b1);
      OP_VLINE: for (int i = y; i <= e; i++) plot(x, i, 1'b1);
      OP_RECT: begin
        if (e > 0 && h > 0) begin
          for (int i = x; i <= x + e - 1; i++) begin
            plot(i, y, 1'b1);
            plot(i, y + h - 1, 1'b1);
          end
          for (int i = y; i <= y + h - 1; i++) begin
            plot(x, i, 1'b1);
            plot(x + e - 1, i, 1'b1);
          end
        end
      end
      OP_GLYPH: begin
        start = c.uc ? int'($signed(shadow_cursor)) : x;
        g = glyph_bits(c.ch);
        for (int row = 0; row < 7; row++)
          for (int col = 0; col < 5; col++)
            if (g[34 - 5 * row - col])
              for (int dy = 0; dy < sy; dy++)
                for (int dx = 0; dx < sx; dx++)
                  plot(start + col * sx + dx, y + row * sy + dy, 1'b1);
        shadow_cursor = 10'(start + 5 * sx + int'(shadow_spacing));
      end
      OP_READ: if (c.ri < STORE_BYTES) r.rd = shadow_fb[c.ri];
      default: ;
    endcase
    r.cur = shadow_cursor;
    return r;
  endfunction

  function automatic draw_cmd_t make_cmd(input logic [2:0] op, input int x, input int y,
                                         input int e, input int h);
    draw_cmd_t c;
    c.op = op; c.x = 10'(x); c.y = 10'(y); c.ew = 10'(e); c.h = 10'(h);
    c.on = 1'b1; c.ch = 7'h41; c.sx = 3'd1; c.sy = 3'd1; c.uc = 1'b0; c.ri = '0;
    return c;
  endfunction

  function automatic draw_cmd_t glyph_cmd(input int x, input int y, input logic [6:0] ch,
                                          input int sx, input int sy, input bit uc);
    draw_cmd_t c;
    c = make_cmd(OP_GLYPH, x, y, 0, 0);
    c.ch = ch; c.sx = 3'(sx); c.sy = 3'(sy); c.uc = uc;
    return c;
  endfunction

  function automatic draw_cmd_t read_cmd(input int idx);
    draw_cmd_t c;
    c = make_cmd(OP_READ, 0, 0, 0, 0);
    c.ri = 10'(idx);
    return c;
  endfunction

  // Present one beat and hold it until taken; called at a rising edge
  task automatic send_cmd(input draw_cmd_t c);
    in_valid <= 1'b1;
    opcode <= c.op; pos_x <= c.x; pos_y <= c.y;
    line_end_or_width <= c.ew; rect_height <= c.h; pixel_on <= c.on;
    char_code <= c.ch; scale_x <= c.sx; scale_y <= c.sy;
    use_cursor <= c.uc; read_index <= c.ri;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_draw(c));
  endtask

  // Drop valid and wait for every result, then let the engine settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [3:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_spacing = v;
  endtask

  // Insert a random gap once the current burst runs out
  task automatic burst_gap();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic test_reset_state();
    send_cmd(read_cmd(0));
    send_cmd(read_cmd(STORE_BYTES - 1));
  endtask

  task automatic test_pixels();
    draw_cmd_t c;
    send_cmd(make_cmd(OP_PIXEL, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_PIXEL, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0));
    send_cmd(make_cmd(OP_PIXEL, -512, 511, 0, 0));
    c = make_cmd(OP_PIXEL, 0, 0, 0, 0);
    c.on = 1'b0;
    send_cmd(c);
    send_cmd(read_cmd(0));
    send_cmd(read_cmd(STORE_BYTES - 1));
  endtask

  task automatic test_lines();
    send_cmd(make_cmd(OP_HLINE, -512, 9, 511, 0));
    send_cmd(make_cmd(OP_HLINE, 40, 3, 39, 0));
    send_cmd(make_cmd(OP_VLINE, 127, -512, 511, 0));
    send_cmd(make_cmd(OP_VLINE, 5, 20, 10, 0));
    send_cmd(read_cmd(SCREEN_WIDTH + 60));
  endtask

  task automatic test_rects();
    send_cmd(make_cmd(OP_RECT, 10, 10, 0, 5));
    send_cmd(make_cmd(OP_RECT, 10, 10, 5, -3));
    send_cmd(make_cmd(OP_RECT, -5, -5, 140, 80));
    send_cmd(make_cmd(OP_RECT, 30, 30, 1, 1));
    send_cmd(read_cmd(3 * SCREEN_WIDTH + 30));
  endtask

  task automatic test_glyphs();
    send_cmd(glyph_cmd(0, 0, 7'h30, 1, 1, 1'b0));
    send_cmd(glyph_cmd(0, 0, 7'h41, 2, 3, 1'b1));
    send_cmd(glyph_cmd(0, 20, 7'h7F, 4, 4, 1'b1));
    send_cmd(glyph_cmd(50, 40, 7'h38, 0, 0, 1'b0));
    send_cmd(glyph_cmd(90, 30, 7'h4D, 7, 7, 1'b0));
    // push the cursor past the positive end so it wraps
    send_cmd(glyph_cmd(505, 0, 7'h20, 4, 1, 1'b0));
    send_cmd(glyph_cmd(0, 0, 7'h6E, 1, 1, 1'b1));
    send_cmd(read_cmd(4 * SCREEN_WIDTH + 100));
  endtask

  task automatic test_clear_unused();
    send_cmd(make_cmd(OP_UNUSED, 1, 1, 1, 1));
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0));
    send_cmd(read_cmd(SCREEN_WIDTH + 60));
  endtask

  task automatic test_spacing_extremes();
    write_spacing(4'd0);
    send_cmd(glyph_cmd(3, 8, 7'h31, 1, 1, 1'b0));
    send_cmd(glyph_cmd(0, 8, 7'h32, 1, 1, 1'b1));
    write_spacing(4'd15);
    send_cmd(glyph_cmd(0, 16, 7'h33, 3, 2, 1'b1));
    send_cmd(glyph_cmd(0, 16, 7'h34, 1, 1, 1'b1));
  endtask

  function automatic int near_coord(input int span);
    if ($urandom_range(0, 15) == 0) return int'($signed(10'($urandom)));
    return int'($urandom_range(0, span + 24)) - 12;
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int pick;
    c.x = 10'(near_coord(SCREEN_WIDTH));
    c.y = 10'(near_coord(SCREEN_HEIGHT));
    c.on = 1'($urandom_range(0, 1));
    c.uc = 1'($urandom_range(0, 1));
    c.ri = 10'($urandom);
    c.h = 10'($urandom);
    c.ch = ($urandom_range(0, 9) < 7) ? FONT[$urandom_range(0, 29)][41:35] : 7'($urandom);
    if ($urandom_range(0, 19) == 0) begin
      c.sx = 3'($urandom); c.sy = 3'($urandom);
    end else begin
      c.sx = 3'($urandom_range(1, 4)); c.sy = 3'($urandom_range(1, 4));
    end
    pick = $urandom_range(0, 99);
    if (pick < 1) c.op = OP_CLEAR;
    else if (pick < 21) c.op = OP_PIXEL;
    else if (pick < 33) c.op = OP_HLINE;
    else if (pick < 45) c.op = OP_VLINE;
    else if (pick < 53) c.op = OP_RECT;
    else if (pick < 73) c.op = OP_GLYPH;
    else if (pick < 98) c.op = OP_READ;
    else c.op = OP_UNUSED;
    // keep most lines and boxes short so the run stays quick
    if ($urandom_range(0, 19) == 0) c.ew = 10'($urandom);
    else if (c.op == OP_HLINE) c.ew = 10'(int'(c.x) + int'($urandom_range(0, 44)) - 4);
    else if (c.op == OP_VLINE) c.ew = 10'(int'(c.y) + int'($urandom_range(0, 44)) - 4);
    else c.ew = 10'(int'($urandom_range(0, 42)) - 2);
    if (c.op == OP_RECT && $urandom_range(0, 9) != 0)
      c.h = 10'(int'($urandom_range(0, 30)) - 2);
    return c;
  endfunction

  task automatic test_random();
    burst_left = 0;
    for (int i = 0; i < 1700; i++) begin
      if (i % 400 == 399) write_spacing(4'($urandom));
      burst_gap();
      send_cmd(random_cmd());
    end
  endtask

  // Receiver stall pattern: switches among off, sparse random and periodic
  int stall_mode;
  int stall_count;
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_count <= $urandom_range(50, 300);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= (stall_count % 7) < 3;
    endcase
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    draw_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, read_data", read_data, 0);
      end else begin
        want = pending_results.pop_front();
        if (read_data !== want.rd) report_mismatch("read_data", read_data, want.rd);
        if (next_cursor !== want.cur)
          report_mismatch("next_cursor", next_cursor, want.cur);
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    err_count = 0;
    idle_cycles = 0;
    stall_count = 0;
    stall_mode = 0;
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    shadow_cursor = '0;
    shadow_spacing = 4'd1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_pixels();
    test_lines();
    test_rects();
    test_glyphs();
    test_clear_unused();
    test_spacing_extremes();
    write_spacing(4'd1);
    test_random();
    wait_idle();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
